### rtl/gccb_pkg.sv
package gccb_pkg;

  localparam int unsigned DenomNum = 10;
  localparam int unsigned DenIdxW  = 4;
  localparam int unsigned DenomW   = 16;
  // remainder after the 50000s is below the largest denomination
  localparam int unsigned RemW     = DenomW;
  localparam int unsigned Cnt0W    = 9;
  localparam int unsigned SubCntW  = 2;
  localparam int unsigned LeftW    = 6;

  // 50000 = 16 * 3125: drop the low 4 bits, then multiply by the rounded-up
  // reciprocal of 3125; floor(y * QUOT_MUL / 2^40) equals floor(y / 3125) for y below 2^28
  localparam int unsigned AmtExtW   = 32;
  localparam int unsigned PreShift  = 4;
  localparam int unsigned MulW      = 29;
  localparam int unsigned QuotShift = 40;
  localparam int unsigned ProdW     = AmtExtW - PreShift + MulW;
  localparam int unsigned QuotW     = ProdW - QuotShift;
  localparam logic [MulW-1:0] QUOT_MUL = 29'd351843721;

  localparam logic [DenomW-1:0] DENOM_TAB [DenomNum] = '{
    16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd2000,
    16'd1000,  16'd500,   16'd200,   16'd100,  16'd50
  };

  localparam logic [DenIdxW-1:0] DEN_FIRST_SUB = 4'd1;
  localparam logic [DenIdxW-1:0] DEN_LAST      = 4'd9;
  localparam logic [Cnt0W-1:0]   CNT0_MAX      = 9'd511;

  typedef struct packed {
    logic               load;
    logic               quot_step;
    logic               rem_step;
    logic               sub_step;
    logic               out_load;
    logic [DenIdxW-1:0] den_idx;
  } gccb_cmd_t;

  typedef struct packed {
    logic rest_ge;
  } gccb_stat_t;

endpackage

### rtl/gccb_datapath.sv
module gccb_datapath import gccb_pkg::*; #(
  parameter int unsigned AMOUNT_BITS = 24
) (
  input  logic                   clk_i,
  input  logic [AMOUNT_BITS-1:0] amount_i,
  input  gccb_cmd_t              cmd_i,
  output gccb_stat_t             stat_o,
  output logic [8:0]             count_fifty_thousand_o,
  output logic [1:0]             count_twenty_thousand_o,
  output logic                   count_ten_thousand_o,
  output logic                   count_five_thousand_o,
  output logic [1:0]             count_two_thousand_o,
  output logic                   count_one_thousand_o,
  output logic                   count_five_hundred_o,
  output logic [1:0]             count_two_hundred_o,
  output logic                   count_one_hundred_o,
  output logic                   count_fifty_o,
  output logic [5:0]             leftover_o
);

  logic [AMOUNT_BITS-1:0] amt_q;
  logic [QuotW-1:0]       quot_q;
  logic [RemW-1:0]        rem_q;
  logic [SubCntW-1:0]     cnt_q [1:DenomNum-1];

  logic [AmtExtW-1:0]     amt_ext;
  logic [ProdW-1:0]       prod;
  logic [AmtExtW-1:0]     rem_full;
  logic [RemW-1:0]        sub_denom;
  logic                   sub_ge;
  logic [Cnt0W-1:0]       cnt0;

  assign amt_ext   = AmtExtW'(amt_q);
  // quotient by 50000 through the reciprocal, remainder in the following cycle
  assign prod      = ProdW'(amt_ext[AmtExtW-1:PreShift]) * ProdW'(QUOT_MUL);
  assign rem_full  = amt_ext - AmtExtW'(quot_q) * AmtExtW'(DENOM_TAB[0]);
  assign sub_denom = RemW'(DENOM_TAB[cmd_i.den_idx]);
  assign sub_ge    = rem_q >= sub_denom;

  assign stat_o.rest_ge = sub_ge;

  // saturate the quotient to the 9-bit count
  assign cnt0 = (|quot_q[QuotW-1:Cnt0W]) ? CNT0_MAX : quot_q[Cnt0W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      amt_q <= amount_i;
      for (int k = 1; k < DenomNum; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cmd_i.quot_step) begin
      quot_q <= prod[QuotShift +: QuotW];
    end else if (cmd_i.rem_step) begin
      rem_q <= rem_full[RemW-1:0];
    end else if (cmd_i.sub_step && sub_ge) begin
      rem_q                  <= rem_q - sub_denom;
      cnt_q[cmd_i.den_idx]   <= cnt_q[cmd_i.den_idx] + SubCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      count_fifty_thousand_o  <= cnt0;
      count_twenty_thousand_o <= cnt_q[1];
      count_ten_thousand_o    <= cnt_q[2][0];
      count_five_thousand_o   <= cnt_q[3][0];
      count_two_thousand_o    <= cnt_q[4];
      count_one_thousand_o    <= cnt_q[5][0];
      count_five_hundred_o    <= cnt_q[6][0];
      count_two_hundred_o     <= cnt_q[7];
      count_one_hundred_o     <= cnt_q[8][0];
      count_fifty_o           <= cnt_q[9][0];
      leftover_o              <= rem_q[LeftW-1:0];
    end
  end

endmodule

### rtl/gccb_ctrl.sv
module gccb_ctrl import gccb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  gccb_stat_t stat_i,
  output gccb_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_SUB,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [DenIdxW-1:0] den_idx_q;
  logic               out_valid_q;
  logic               out_free;
  logic               in_take;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.den_idx   = den_idx_q;
    cmd_o.load      = in_take;
    cmd_o.quot_step = (state_q == ST_QUOT);
    cmd_o.rem_step  = (state_q == ST_REM);
    cmd_o.sub_step  = (state_q == ST_SUB);
    cmd_o.out_load  = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      den_idx_q   <= DEN_FIRST_SUB;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once the transaction completes
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          state_q <= ST_REM;
        end
        ST_REM: begin
          den_idx_q <= DEN_FIRST_SUB;
          state_q   <= ST_SUB;
        end
        ST_SUB: begin
          // stay on a denomination while it still fits, else advance
          if (!stat_i.rest_ge) begin
            if (den_idx_q == DEN_LAST) begin
              state_q <= ST_DONE;
            end else begin
              den_idx_q <= den_idx_q + DenIdxW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/greedy_cash_change_breakdown.sv
// From an accepted amount to out_valid_o: the reciprocal multiply gives the 50000s, then the
// remainder is taken, then each subtract or denomination advance is one step (9 advances
// plus up to 12 subtracts), and last the result is loaded.
// Only one amount is in flight; the next is accepted once the controller is back in idle,
// which waits while the result register still holds a stalled earlier result.
// Reset (rst_ni low, asynchronous) returns the controller to idle and clears out_valid_o.
module greedy_cash_change_breakdown import gccb_pkg::*; #(
  parameter int unsigned AMOUNT_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [AMOUNT_BITS-1:0] amount_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [8:0]             count_fifty_thousand_o,
  output logic [1:0]             count_twenty_thousand_o,
  output logic                   count_ten_thousand_o,
  output logic                   count_five_thousand_o,
  output logic [1:0]             count_two_thousand_o,
  output logic                   count_one_thousand_o,
  output logic                   count_five_hundred_o,
  output logic [1:0]             count_two_hundred_o,
  output logic                   count_one_hundred_o,
  output logic                   count_fifty_o,
  output logic [5:0]             leftover_o
);

  gccb_cmd_t  cmd;
  gccb_stat_t stat;

  gccb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gccb_datapath #(
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_datapath (
    .clk_i                  (clk_i),
    .amount_i               (amount_i),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .count_fifty_thousand_o (count_fifty_thousand_o),
    .count_twenty_thousand_o(count_twenty_thousand_o),
    .count_ten_thousand_o   (count_ten_thousand_o),
    .count_five_thousand_o  (count_five_thousand_o),
    .count_two_thousand_o   (count_two_thousand_o),
    .count_one_thousand_o   (count_one_thousand_o),
    .count_five_hundred_o   (count_five_hundred_o),
    .count_two_hundred_o    (count_two_hundred_o),
    .count_one_hundred_o    (count_one_hundred_o),
    .count_fifty_o          (count_fifty_o),
    .leftover_o             (leftover_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting an amount");

  a_leftover_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (leftover_o < 6'd50))
    else $error("leftover not below smallest denomination");

  a_sub_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_twenty_thousand_o != 2'd3) && (count_two_thousand_o != 2'd3)
                    && (count_two_hundred_o != 2'd3))
    else $error("denomination count out of range");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule
